@@ rtl/core/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants of the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

    localparam int unsigned NODES_DEF    = 256;
    localparam int unsigned KEY_BITS_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  node_id;
        logic [31:0] distance;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_node;
        logic [31:0] out_distance;
        logic        present;
        logic        now_empty;
        logic [1:0]  status;
        logic [8:0]  count;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_RD,
        ST_POS_CHK,
        ST_EXT_RD,
        ST_EXT_WR,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/indexed_min_heap.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with decrease/increase key, extract-min and query.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Word
// in       input      i_in_valid / o_in_stall   t_in_word (func, node_id, distance)
// out      output     o_out_valid / i_out_stall t_out_word (one per input word)
//
// One word at a time: a new word is accepted only while idle with no result waiting.
// Inserts and key updates sift up or down; an extract sifts the last entry down.
// After reset a clearing pass writes every position map entry (NODES at the
// default size), marking every node absent; o_in_stall stays high during it.
// The result sits in an output register; o_in_stall holds while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap #(
    parameter int unsigned NODES    = imh_pkg::NODES_DEF,
    parameter int unsigned KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire imh_pkg::t_in_word i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      imh_pkg::t_out_word o_out_data
);
    import imh_pkg::*;

    localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned CW = AW + 1;   // count holds NODES itself
    localparam int unsigned NW = (AW < 8) ? AW : 8;
    localparam int unsigned PD = 1 << NW;  // position map depth
    localparam int unsigned PW = AW + 1;   // valid bit + slot

    t_state r_state, n_state;

    // latched input word
    logic [1:0]          r_func;
    logic [7:0]          r_node;
    logic [KEY_BITS-1:0] r_key;

    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_i, n_i;        // current sift slot
    logic [KEY_BITS-1:0] r_ckey, n_ckey;  // key of moving entry
    logic [7:0]          r_cid, n_cid;    // id of moving entry
    logic                r_down, n_down;  // sift direction
    logic [NW:0]         r_clr, n_clr;
    t_out_word           r_out, n_out;
    logic                r_ov, n_ov;

    // memory ports
    logic                he_we;
    logic [AW-1:0]       he_waddr, he_ra, he_rb;
    logic [KEY_BITS-1:0] he_wkey, key_a, key_b;
    logic [7:0]          he_wid, id_a, id_b;
    logic                pm_we;
    logic [NW-1:0]       pm_waddr, pm_raddr;
    logic [PW-1:0]       pm_wdata, pm_rdata;

    logic                node_ok;
    logic [KEY_BITS-1:0] in_key;
    logic [CW:0]         l_idx, r_idx;
    logic                l_ok, r_ok, take_l, take_r;
    logic [AW-1:0]       par;

    imh_heap_mem #(.DEPTH(NODES), .KEY_BITS(KEY_BITS), .AW(AW)) u_heap (
        .i_clk    (i_clk),
        .i_we     (he_we),
        .i_waddr  (he_waddr),
        .i_wkey   (he_wkey),
        .i_wid    (he_wid),
        .i_raddr_a(he_ra),
        .i_raddr_b(he_rb),
        .o_key_a  (key_a),
        .o_id_a   (id_a),
        .o_key_b  (key_b),
        .o_id_b   (id_b)
    );

    imh_pos_mem #(.DEPTH(PD), .NW(NW), .PW(PW)) u_pos (
        .i_clk  (i_clk),
        .i_we   (pm_we),
        .i_waddr(pm_waddr),
        .i_wdata(pm_wdata),
        .i_raddr(pm_raddr),
        .o_rdata(pm_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // node ids at or beyond NODES are never stored
    assign node_ok = ({24'd0, r_node} < 32'(NODES));
    assign in_key  = KEY_BITS'(i_in_data.distance);

    assign l_idx  = (CW+1)'({r_i, 1'b1});
    assign r_idx  = (CW+1)'({r_i, 1'b0}) + (CW+1)'(2);
    assign l_ok   = l_idx < (CW+1)'(r_count);
    assign r_ok   = r_idx < (CW+1)'(r_count);
    assign take_l = l_ok && (key_a < r_ckey) && !(r_ok && key_b < key_a);
    assign take_r = r_ok && (key_b < r_ckey) && !take_l;
    assign par    = AW'((r_i - AW'(1)) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid && !o_in_stall) begin
            r_func <= i_in_data.func;
            r_node <= i_in_data.node_id;
            r_key  <= in_key;
        end
        r_i    <= n_i;
        r_ckey <= n_ckey;
        r_cid  <= n_cid;
        r_down <= n_down;
        r_out  <= n_out;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == (NW+1)'(PD - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_state = (i_in_data.func == FUNC_EXTRACT) ? ST_EXT_RD : ST_POS_RD;
                end
            end
            ST_POS_RD: n_state = ST_POS_CHK;
            ST_POS_CHK: begin
                if (r_func != FUNC_INSERT || !node_ok) begin
                    n_state = ST_DONE;
                end else if (pm_rdata[PW-1]) begin
                    n_state = ST_DN_RD; // refined below by the key compare
                end else if (r_count >= CW'(NODES)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_UP_RD;
                end
            end
            // an empty heap, or one whose last entry leaves, has nothing to sift
            ST_EXT_RD: n_state = (r_count <= CW'(1)) ? ST_DONE : ST_EXT_WR;
            ST_EXT_WR: n_state = ST_DN_RD;
            ST_UP_RD:  n_state = (r_i == '0) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP: n_state = (r_ckey < key_a) ? ST_UP_RD : ST_DONE;
            ST_DN_RD:  n_state = r_down ? ST_DN_CMP : ST_DONE;
            ST_DN_CMP: n_state = (take_l || take_r) ? ST_DN_RD : ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        // an update that moves nothing ends at once; upward goes to sift-up
        if (r_state == ST_POS_CHK && n_state == ST_DN_RD) begin
            if (r_key < key_a)      n_state = ST_UP_RD;
            else if (key_a < r_key) n_state = ST_DN_RD;
            else                    n_state = ST_DONE;
        end
    end

    // datapath and memory control
    always_comb begin
        n_count  = r_count;
        n_i      = r_i;
        n_ckey   = r_ckey;
        n_cid    = r_cid;
        n_down   = r_down;
        n_clr    = r_clr;
        n_out    = r_out;
        n_ov     = r_ov && i_out_stall;
        he_we    = 1'b0;
        he_waddr = r_i;
        he_wkey  = r_ckey;
        he_wid   = r_cid;
        he_ra    = r_i;
        he_rb    = r_i;
        pm_we    = 1'b0;
        pm_waddr = NW'(r_cid);
        pm_wdata = {1'b1, r_i};
        pm_raddr = NW'(r_node);

        unique case (r_state)
            ST_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = r_clr[NW-1:0];
                pm_wdata = '0;
                n_clr    = r_clr + 1'b1;
            end
            ST_IDLE: begin
                pm_raddr = NW'(i_in_data.node_id);
                he_ra    = '0;
                he_rb    = AW'(r_count - 1'b1);
                // hold the waiting result word
                if (!r_ov) n_out = '0;
                n_down   = 1'b0;
            end
            ST_POS_RD: begin
                // position map data arrives; read the node's slot next
                he_ra = pm_rdata[AW-1:0];
            end
            ST_POS_CHK: begin
                n_cid  = r_node;
                n_ckey = r_key;
                if (r_func == FUNC_QUERY) begin
                    n_out.present = node_ok && pm_rdata[PW-1];
                end else if (r_func == FUNC_INSERT && node_ok) begin
                    if (pm_rdata[PW-1]) begin
                        n_i   = pm_rdata[AW-1:0];
                        he_ra = pm_rdata[AW-1:0];
                        n_down = 1'b1;
                    end else if (r_count >= CW'(NODES)) begin
                        n_out.status = STATUS_FULL;
                    end else begin
                        n_i     = r_count[AW-1:0];
                        n_count = r_count + 1'b1;
                        he_ra   = AW'((r_count[AW-1:0] - AW'(1)) >> 1);
                    end
                end
            end
            ST_EXT_RD: begin
                if (r_count == '0) begin
                    n_out.status = STATUS_EMPTY;
                end else begin
                    n_out.out_node     = id_a;
                    n_out.out_distance = 32'(key_a);
                    n_ckey  = key_b;
                    n_cid   = id_b;
                    n_i     = '0;
                    n_count = r_count - 1'b1;
                    n_down  = 1'b1;
                    pm_we    = 1'b1;
                    pm_waddr = NW'(id_a);
                    pm_wdata = '0;
                end
            end
            ST_EXT_WR: begin
                he_ra = AW'(1);
                he_rb = AW'(2);
            end
            ST_UP_RD: begin
                // moving entry sits (logically) at r_i; hold the parent read
                he_ra = par;
                if (r_i == '0) begin
                    he_we = 1'b1;
                    pm_we = 1'b1;
                end
            end
            ST_UP_CMP: begin
                if (r_ckey < key_a) begin
                    // pull parent down into r_i, move up
                    he_we    = 1'b1;
                    he_wkey  = key_a;
                    he_wid   = id_a;
                    pm_we    = 1'b1;
                    pm_waddr = NW'(id_a);
                    n_i      = par;
                    he_ra    = AW'((par - AW'(1)) >> 1);
                end else begin
                    he_we = 1'b1;
                    pm_we = 1'b1;
                end
            end
            ST_DN_RD: begin
                // hold the child reads for the compare
                he_ra = AW'({r_i, 1'b1});
                he_rb = AW'(({r_i, 1'b0}) + 2);
                if (!r_down) begin
                    he_we = 1'b1;
                    pm_we = 1'b1;
                end
            end
            ST_DN_CMP: begin
                if (take_l || take_r) begin
                    he_we    = 1'b1;
                    he_wkey  = take_l ? key_a : key_b;
                    he_wid   = take_l ? id_a : id_b;
                    pm_we    = 1'b1;
                    pm_waddr = NW'(take_l ? id_a : id_b);
                    n_i      = take_l ? AW'(l_idx) : AW'(r_idx);
                    he_ra    = AW'({n_i, 1'b1});
                    he_rb    = AW'(({n_i, 1'b0}) + 2);
                end else begin
                    he_we = 1'b1;
                    pm_we = 1'b1;
                end
            end
            ST_DONE: begin
                n_out.count     = 9'(n_count);
                n_out.now_empty = (r_count == '0);
                n_ov            = 1'b1;
            end
            default: ;
        endcase

        // sift-down read addresses follow the current slot
        if (r_state == ST_POS_CHK && pm_rdata[PW-1] && r_func == FUNC_INSERT && node_ok
            && !(r_key < key_a)) begin
            he_ra = AW'({pm_rdata[AW-1:0], 1'b1});
            he_rb = AW'(({pm_rdata[AW-1:0], 1'b0}) + 2);
        end
        if (r_state == ST_POS_CHK && pm_rdata[PW-1] && r_func == FUNC_INSERT && node_ok
            && r_key < key_a) begin
            n_down = 1'b0;
            he_ra  = AW'((pm_rdata[AW-1:0] - AW'(1)) >> 1);
        end
        if (r_state == ST_POS_CHK && pm_rdata[PW-1] && r_func == FUNC_INSERT && node_ok
            && r_key == key_a) begin
            n_down = 1'b0;
        end
        // an equal-key update writes nothing; an increase leaves r_down set
        if (r_state == ST_DN_RD && !r_down) begin
            he_we = 1'b1;
            pm_we = 1'b1;
        end
    end
endmodule

`default_nettype wire

@@ rtl/core/imh_heap_mem.sv @@
// ----------------------------------------------------------------------------
// imh_heap_mem
// Heap slot store: key and id per slot, one write and two reads per cycle,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_heap_mem #(
    parameter int unsigned DEPTH    = 256,
    parameter int unsigned KEY_BITS = 32,
    parameter int unsigned AW       = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [KEY_BITS-1:0] i_wkey,
    input  wire logic [7:0]          i_wid,
    input  wire logic [AW-1:0]       i_raddr_a,
    input  wire logic [AW-1:0]       i_raddr_b,
    output      logic [KEY_BITS-1:0] o_key_a,
    output      logic [7:0]          o_id_a,
    output      logic [KEY_BITS-1:0] o_key_b,
    output      logic [7:0]          o_id_b
);
    logic [KEY_BITS+7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wkey, i_wid};
        end
        {o_key_a, o_id_a} <= r_mem[i_raddr_a];
        {o_key_b, o_id_b} <= r_mem[i_raddr_b];
    end
endmodule

`default_nettype wire

@@ rtl/core/imh_pos_mem.sv @@
// ----------------------------------------------------------------------------
// imh_pos_mem
// Position map: valid bit and slot per node, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_pos_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned NW    = 8,
    parameter int unsigned PW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [NW-1:0] i_waddr,
    input  wire logic [PW-1:0] i_wdata,
    input  wire logic [NW-1:0] i_raddr,
    output      logic [PW-1:0] o_rdata
);
    logic [PW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ bench/tb_indexed_min_heap.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// Self-checking bench for the indexed min-heap: a behavioral heap predicts
// every output word, which a monitor compares field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_indexed_min_heap;
    import imh_pkg::*;

    localparam int NODES = 256;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    indexed_min_heap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Behavioral heap state.
    logic [31:0] heap_key [NODES];
    logic [7:0]  heap_id  [NODES];
    int          slot_of  [NODES];
    bit          in_heap  [NODES];
    int          heap_size;

    t_out_word   expected_words[$];
    int          error_count;
    bit          idle_enable;
    bit          send_done;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit: generous against ~1800 words at worst-case stall and sift.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic void swap_slots(input int a, input int b);
        logic [31:0] k;
        logic [7:0]  n;
        k = heap_key[a]; n = heap_id[a];
        heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
        heap_key[b] = k; heap_id[b] = n;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    function automatic void sift_up(input int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(heap_key[i] < heap_key[p])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sift_down(input int i);
        int best;
        int l;
        while (i < heap_size) begin
            best = i;
            l = 2 * i + 1;
            if (l < heap_size && heap_key[l] < heap_key[best]) best = l;
            if (l + 1 < heap_size && heap_key[l + 1] < heap_key[best]) best = l + 1;
            if (best == i) break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    // Advance the heap by one word and return the word it answers with.
    function automatic t_out_word predict_heap_op(input t_in_word w);
        t_out_word r;
        logic [31:0] old;
        int i;
        int last;
        r = '0;
        case (t_func'(w.func))
            FUNC_INSERT: begin
                if (in_heap[w.node_id]) begin
                    i = slot_of[w.node_id];
                    old = heap_key[i];
                    heap_key[i] = w.distance;
                    if (w.distance < old) sift_up(i);
                    else if (old < w.distance) sift_down(i);
                end else if (heap_size >= NODES) begin
                    r.status = STATUS_FULL;
                end else begin
                    i = heap_size;
                    heap_key[i] = w.distance;
                    heap_id[i] = w.node_id;
                    slot_of[w.node_id] = i;
                    in_heap[w.node_id] = 1'b1;
                    heap_size++;
                    sift_up(i);
                end
            end
            FUNC_EXTRACT: begin
                if (heap_size == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    last = heap_size - 1;
                    r.out_node = heap_id[0];
                    r.out_distance = heap_key[0];
                    in_heap[heap_id[0]] = 1'b0;
                    heap_key[0] = heap_key[last];
                    heap_id[0] = heap_id[last];
                    heap_size = last;
                    if (last > 0) slot_of[heap_id[0]] = 0;
                    sift_down(0);
                end
            end
            FUNC_QUERY: r.present = in_heap[w.node_id];
            default: ;
        endcase
        r.now_empty = (heap_size == 0);
        r.count = heap_size[8:0];
        return r;
    endfunction

    // Send one word: random gap before, hold until accepted. Valid stays high
    // into the next call so each falling edge carries one update only.
    task automatic send_word(input t_func f, input logic [7:0] node,
                             input logic [31:0] key_val);
        t_in_word w;
        w.func = f; w.node_id = node; w.distance = key_val;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_words.push_back(predict_heap_op(w));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Monitor: compare each accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_out_data.count), 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_data.out_node !== want.out_node)
                    report_mismatch("out_node", 32'(o_out_data.out_node),
                                    32'(want.out_node));
                if (o_out_data.out_distance !== want.out_distance)
                    report_mismatch("out_distance", o_out_data.out_distance,
                                    want.out_distance);
                if (o_out_data.present !== want.present)
                    report_mismatch("present", 32'(o_out_data.present),
                                    32'(want.present));
                if (o_out_data.now_empty !== want.now_empty)
                    report_mismatch("now_empty", 32'(o_out_data.now_empty),
                                    32'(want.now_empty));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.count !== want.count)
                    report_mismatch("count", 32'(o_out_data.count), 32'(want.count));
            end
        end
    end

    // Receiver stall: random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (idle_enable && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 6);
        if (idle_enable && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end
    end

    // Directed: empty extract, extremes of keys and ids, ties, update
    // both ways, equal-key update, query, unused func.
    task automatic test_directed();
        send_word(FUNC_EXTRACT, 8'd0, 32'd0);
        send_word(FUNC_QUERY, 8'd0, 32'd0);
        send_word(FUNC_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 8'd0, 32'd0);
        send_word(FUNC_INSERT, 8'd7, 32'd100);
        send_word(FUNC_INSERT, 8'd8, 32'd100);
        send_word(FUNC_INSERT, 8'd9, 32'd100);
        send_word(FUNC_QUERY, 8'd255, 32'd0);
        send_word(FUNC_QUERY, 8'd1, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 8'd255, 32'd5);
        send_word(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 8'd8, 32'd100);
        send_word(FUNC_NONE, 8'hAA, 32'h5555_AAAA);
        repeat (6) send_word(FUNC_EXTRACT, 8'hFF, 32'hFFFF_FFFF);
        send_word(FUNC_QUERY, 8'd0, 32'd0);
    endtask

    // Fill to capacity, update and query a present node, then drain completely and extract once more.
    task automatic test_full_heap();
        for (int n = 0; n < NODES; n++)
            send_word(FUNC_INSERT, n[7:0], random_key());
        send_word(FUNC_INSERT, 8'd17, 32'd3);
        send_word(FUNC_QUERY, 8'd17, 32'd0);
        for (int n = 0; n < NODES + 1; n++)
            send_word(FUNC_EXTRACT, 8'd0, 32'd0);
    endtask

    // Dijkstra-like mix over a small node range so updates and hits are common.
    task automatic test_random_mix(input int words);
        logic [7:0] node;
        int pick;
        for (int k = 0; k < words; k++) begin
            node = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            pick = $urandom_range(0, 9);
            if (pick < 5) send_word(FUNC_INSERT, node, random_key());
            else if (pick < 8) send_word(FUNC_EXTRACT, 8'($urandom), $urandom);
            else if (pick < 9) send_word(FUNC_QUERY, node, $urandom);
            else send_word(FUNC_NONE, node, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        idle_enable = 1'b1;
        error_count = 0;
        heap_size = 0;
        for (int n = 0; n < NODES; n++) begin
            in_heap[n] = 1'b0;
            slot_of[n] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_heap();
        test_random_mix(1000);
        idle_enable = 1'b0;
        test_random_mix(200);
        i_in_valid <= 1'b0;

        fork
            begin
                while (expected_words.size() != 0) @(posedge i_clk);
                repeat (40) @(posedge i_clk);
            end
            begin
                repeat (20000) @(posedge i_clk);
                error_count++;
                $display("drain timeout");
            end
        join_any
        if (error_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/imh_pkg.sv
rtl/core/imh_heap_mem.sv
rtl/core/imh_pos_mem.sv
rtl/core/indexed_min_heap.sv
bench/tb_indexed_min_heap.sv
